@@ rtl/soft_knee_gain_computer_core_defines.svh @@
// ============================================================================
// Soft-knee gain computer assertion macros
// Concurrent assertion wrappers used by the gain computer core.
// ============================================================================
`ifndef SOFT_KNEE_GAIN_COMPUTER_CORE_DEFINES_SVH
`define SOFT_KNEE_GAIN_COMPUTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SKGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skgc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skgc assertion failed");

`else

`define SKGC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SKGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/skgc_pkg.sv @@
// ============================================================================
// Soft-knee gain computer package
// Field widths, register defaults, register indexes and datapath types.
// ============================================================================
package skgc_pkg;

    // Port field widths.
    localparam int LEVEL_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int THR_W     = 15;
    localparam int KNEE_W    = 13;
    localparam int RATIO_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Internal datapath widths.
    localparam int OVER_W = LEVEL_W + 1;       // level minus threshold
    localparam int MAG_W  = LEVEL_W;           // positive part of the overshoot
    localparam int D_W    = KNEE_W + 1;        // 2*over + W, inside the knee
    localparam int DD_W   = 2 * D_W;           // d squared
    localparam int LIN_W  = RATIO_W + MAG_W;   // slope * over
    localparam int RW_W   = RATIO_W + KNEE_W;  // r * W
    localparam int KNUM_W = RATIO_W + DD_W;    // slope * d^2
    localparam int NUM_W  = KNUM_W + 1;        // dividend plus rounding term
    localparam int DEN_W  = RW_W + 3;          // 8 * r * W
    localparam int Q_W    = 16;                // quotient bits, magnitude < 2^16
    localparam int EXT_W  = DEN_W + Q_W + 1;   // trial subtract width

    // Register reset values.
    localparam logic signed [THR_W-1:0] THRESHOLD_RST = -15'sd5120;
    localparam logic [KNEE_W-1:0]       KNEE_RST      = 13'd1536;
    localparam logic [RATIO_W-1:0]      RATIO_RST     = 10'd64;

    // A ratio of one in Q6.4.
    localparam logic [RATIO_W-1:0] RATIO_ONE = 10'd16;

    // Largest gain magnitude that fits the output field.
    localparam logic [Q_W-1:0] GAIN_MAG_MAX = 16'd32768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd2;

    // Where the level sits relative to the knee.
    typedef enum logic [1:0] {
        REGION_ZERO,
        REGION_KNEE,
        REGION_LINEAR
    } region_t;

    // Payload that flows through the divider stages.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
    } div_t;

endpackage

@@ rtl/skgc_level_if.sv @@
// ============================================================================
// Level channel
// Valid/ready channel that carries one detected level item.
// ============================================================================
interface skgc_level_if
    import skgc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_db;

    modport source (output valid, output level_db, input ready);
    modport sink   (input valid, input level_db, output ready);
endinterface

@@ rtl/skgc_gain_if.sv @@
// ============================================================================
// Gain channel
// Valid/ready channel that carries one gain change item.
// ============================================================================
interface skgc_gain_if
    import skgc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [GAIN_W-1:0] gain_db;

    modport source (output valid, output gain_db, input ready);
    modport sink   (input valid, input gain_db, output ready);
endinterface

@@ rtl/skgc_cfg_if.sv @@
// ============================================================================
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ============================================================================
interface skgc_cfg_if
    import skgc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/soft_knee_gain_computer_core.sv @@
// ============================================================================
// Soft-knee gain computer core
// Maps a detected level in Q7.8 dB to a compressor gain change in Q7.8 dB,
// with a quadratic soft knee, rounding to nearest and output saturation.
// ============================================================================
//
//  Channel  Role   Payload                        Accepted when
//  -------  -----  -----------------------------  --------------------------
//  level    sink   level_db  (16b signed Q7.8)    level.valid && level.ready
//  gain     source gain_db   (16b signed Q7.8)    gain.valid && gain.ready
//  cfg      sink   index (2b), data (16b)         cfg.valid && cfg.ready
//
//  One item per clock while the skid entry is free. Each item passes four front-end
//  stages, sixteen divider stages (one quotient bit each) and the output register.
//  The whole pipeline advances together; a one-entry skid register behind
//  the output register catches the item in flight when the sink stalls, and
//  level.ready drops only while that skid entry is full.
//  Reset clears all valid bits and loads the register defaults (-20 dB
//  threshold, 6 dB knee, 4:1 ratio). Configuration writes are always taken.
//
`include "soft_knee_gain_computer_core_defines.svh"

module soft_knee_gain_computer_core
    import skgc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    skgc_level_if.sink level,
    skgc_gain_if.source gain,
    skgc_cfg_if.sink   cfg
);

    // Configuration registers.
    logic signed [THR_W-1:0] threshold_reg;
    logic [KNEE_W-1:0]       knee_reg;
    logic [RATIO_W-1:0]      ratio_reg;

    // Pipeline advance enable.
    logic en;

    // Front end and divider chain.
    logic           front_vld;
    div_t           front_div;
    logic [Q_W:0]   chain_vld;
    div_t           chain_div [Q_W+1];

    // Output and skid registers.
    logic                     out_vld_reg, out_vld_next;
    logic signed [GAIN_W-1:0] out_gain_reg, out_gain_next;
    logic                     skid_vld_reg, skid_vld_next;
    logic signed [GAIN_W-1:0] skid_gain_reg, skid_gain_next;
    logic                     out_load;
    logic                     pipe_done;
    logic [Q_W-1:0]           mag_sat;
    logic [Q_W:0]             neg_mag;
    logic signed [GAIN_W-1:0] pipe_gain;

    // Configuration writes; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            knee_reg      <= KNEE_RST;
            ratio_reg     <= RATIO_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_THRESHOLD: threshold_reg <= cfg.data[THR_W-1:0];
                REG_KNEE:      knee_reg      <= cfg.data[KNEE_W-1:0];
                REG_RATIO:     ratio_reg     <= cfg.data[RATIO_W-1:0];
                default:       ;
            endcase
        end
    end

    // The pipeline moves whenever the skid entry is free.
    assign en          = !skid_vld_reg;
    assign level.ready = en;

    skgc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (level.valid),
        .level_db  (level.level_db),
        .threshold (threshold_reg),
        .knee      (knee_reg),
        .ratio     (ratio_reg),
        .out_valid (front_vld),
        .out_div   (front_div)
    );

    assign chain_vld[0] = front_vld;
    assign chain_div[0] = front_div;

    // Quotient bits from the most significant down.
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        skgc_div_step #(
            .BIT (Q_W - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_vld[k]),
            .in_div    (chain_div[k]),
            .out_valid (chain_vld[k+1]),
            .out_div   (chain_div[k+1])
        );
    end

    // Saturate the magnitude and apply the sign.
    always_comb
    begin
        mag_sat   = (chain_div[Q_W].quo > GAIN_MAG_MAX) ? GAIN_MAG_MAX : chain_div[Q_W].quo;
        neg_mag   = (Q_W + 1)'(0) - (Q_W + 1)'(mag_sat);
        pipe_gain = $signed(neg_mag[GAIN_W-1:0]);
        pipe_done = chain_vld[Q_W] && en;
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_load       = !out_vld_reg || gain.ready;
        out_vld_next   = out_vld_reg;
        out_gain_next  = out_gain_reg;
        skid_vld_next  = skid_vld_reg;
        skid_gain_next = skid_gain_reg;
        if (out_load)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_gain_next = skid_gain_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next  = pipe_done;
                out_gain_next = pipe_gain;
            end
        end
        else if (pipe_done)
        begin
            skid_vld_next  = 1'b1;
            skid_gain_next = pipe_gain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_gain_reg  <= out_gain_next;
        skid_gain_reg <= skid_gain_next;
    end

    assign gain.valid   = out_vld_reg;
    assign gain.gain_db = out_gain_reg;

    // The gain change is never a boost.
    `SKGC_ASSERT_NOW(a_gain_not_positive, clk, rst_n, gain.valid,
        gain.gain_db[GAIN_W-1] || gain.gain_db == '0)

    // The skid entry only fills behind a held output.
    `SKGC_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_vld_reg, out_vld_reg)

    // An accepted level always lands in the first stage.
    `SKGC_ASSERT_NEXT(a_accept_enters, clk, rst_n, level.valid && level.ready, u_front.s1_vld_reg)

endmodule

@@ rtl/skgc_front.sv @@
// ============================================================================
// Gain computer front end
// Four pipeline stages: knee region decode, products, knee numerator and
// dividend/divisor selection with the rounding term added.
// ============================================================================
module skgc_front
    import skgc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [LEVEL_W-1:0] level_db,
    input  logic signed [THR_W-1:0]   threshold,
    input  logic [KNEE_W-1:0]         knee,
    input  logic [RATIO_W-1:0]        ratio,
    output logic                      out_valid,
    output div_t                      out_div
);

    // Stage 1 results.
    logic               s1_vld_reg;
    region_t            s1_region_reg, s1_region_next;
    logic [D_W-1:0]     s1_d_reg, s1_d_next;
    logic [MAG_W-1:0]   s1_over_reg, s1_over_next;
    logic [RATIO_W-1:0] s1_slope_reg, s1_slope_next;
    logic [RATIO_W-1:0] s1_r_reg, s1_r_next;
    logic [KNEE_W-1:0]  s1_w_reg;

    // Stage 2 results.
    logic               s2_vld_reg;
    region_t            s2_region_reg;
    logic [DD_W-1:0]    s2_dd_reg, s2_dd_next;
    logic [LIN_W-1:0]   s2_lin_reg, s2_lin_next;
    logic [RW_W-1:0]    s2_rw_reg, s2_rw_next;
    logic [RATIO_W-1:0] s2_slope_reg;
    logic [RATIO_W-1:0] s2_r_reg;

    // Stage 3 results.
    logic               s3_vld_reg;
    region_t            s3_region_reg;
    logic [KNUM_W-1:0]  s3_knum_reg, s3_knum_next;
    logic [LIN_W-1:0]   s3_lin_reg;
    logic [RW_W-1:0]    s3_rw_reg;
    logic [RATIO_W-1:0] s3_r_reg;

    // Stage 4 results.
    logic               s4_vld_reg;
    div_t               s4_div_reg, s4_div_next;

    // Stage 1 working values.
    logic signed [OVER_W-1:0]  over;
    logic signed [OVER_W:0]    two_over;
    logic signed [OVER_W:0]    w_ext;
    logic signed [OVER_W:0]    d_full;

    // Stage 4 working values.
    logic [NUM_W-1:0] sel_num;
    logic [DEN_W-1:0] sel_den;

    // Stage 1: overshoot, region and clamped ratio.
    always_comb
    begin
        over     = OVER_W'($signed(level_db)) - OVER_W'($signed(threshold));
        two_over = {over, 1'b0};
        w_ext    = $signed({{(OVER_W + 1 - KNEE_W){1'b0}}, knee});
        d_full   = two_over + w_ext;

        if (knee != '0)
        begin
            if (two_over < -w_ext)
                s1_region_next = REGION_ZERO;
            else if (two_over <= w_ext)
                s1_region_next = REGION_KNEE;
            else
                s1_region_next = REGION_LINEAR;
        end
        else
        begin
            // Hard knee at the threshold.
            if (over > 0)
                s1_region_next = REGION_LINEAR;
            else
                s1_region_next = REGION_ZERO;
        end

        s1_d_next    = d_full[D_W-1:0];
        s1_over_next = over[MAG_W-1:0];
        s1_r_next    = (ratio < RATIO_ONE) ? RATIO_ONE : ratio;
        s1_slope_next = s1_r_next - RATIO_ONE;
    end

    // Stage 2: d squared, linear numerator and r times W.
    always_comb
    begin
        s2_dd_next  = DD_W'(s1_d_reg) * DD_W'(s1_d_reg);
        s2_lin_next = LIN_W'(s1_slope_reg) * LIN_W'(s1_over_reg);
        s2_rw_next  = RW_W'(s1_r_reg) * RW_W'(s1_w_reg);
    end

    // Stage 3: knee numerator.
    always_comb
    begin
        s3_knum_next = KNUM_W'(s2_slope_reg) * KNUM_W'(s2_dd_reg);
    end

    // Stage 4: pick dividend and divisor, add half the divisor for rounding.
    always_comb
    begin
        unique case (s3_region_reg)
            REGION_KNEE:
            begin
                sel_num = NUM_W'(s3_knum_reg);
                sel_den = {s3_rw_reg, 3'b000};
            end
            REGION_LINEAR:
            begin
                sel_num = NUM_W'(s3_lin_reg);
                sel_den = DEN_W'(s3_r_reg);
            end
            default:
            begin
                sel_num = '0;
                sel_den = DEN_W'(s3_r_reg);
            end
        endcase
        s4_div_next.rem = sel_num + NUM_W'(sel_den >> 1);
        s4_div_next.den = sel_den;
        s4_div_next.quo = '0;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_region_reg <= s1_region_next;
            s1_d_reg      <= s1_d_next;
            s1_over_reg   <= s1_over_next;
            s1_slope_reg  <= s1_slope_next;
            s1_r_reg      <= s1_r_next;
            s1_w_reg      <= knee;

            s2_region_reg <= s1_region_reg;
            s2_dd_reg     <= s2_dd_next;
            s2_lin_reg    <= s2_lin_next;
            s2_rw_reg     <= s2_rw_next;
            s2_slope_reg  <= s1_slope_reg;
            s2_r_reg      <= s1_r_reg;

            s3_region_reg <= s2_region_reg;
            s3_knum_reg   <= s3_knum_next;
            s3_lin_reg    <= s2_lin_reg;
            s3_rw_reg     <= s2_rw_reg;
            s3_r_reg      <= s2_r_reg;

            s4_div_reg    <= s4_div_next;
        end
    end

    assign out_valid = s4_vld_reg;
    assign out_div   = s4_div_reg;

endmodule

@@ rtl/skgc_div_step.sv @@
// ============================================================================
// Divider stage
// One restoring division step that settles one quotient bit per stage.
// ============================================================================
module skgc_div_step
    import skgc_pkg::*;
#(
    parameter int unsigned BIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_div,
    output logic out_valid,
    output div_t out_div
);

    logic             vld_reg;
    div_t             div_reg, div_next;
    logic [EXT_W-1:0] diff;
    logic             take;

    // Trial subtract of the divisor aligned to this quotient bit.
    always_comb
    begin
        diff = EXT_W'(in_div.rem) - (EXT_W'(in_div.den) << BIT);
        take = !diff[EXT_W-1];
        div_next = in_div;
        if (take)
        begin
            div_next.rem = diff[NUM_W-1:0];
            div_next.quo = in_div.quo | (Q_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    assign out_valid = vld_reg;
    assign out_div   = div_reg;

endmodule

@@ dv/tb_soft_knee_gain_computer_core.sv @@
// ============================================================================
// Soft-knee gain computer core testbench
// Drives detected levels through the level channel and register writes through
// the configuration channel, with random source gaps and sink stalls. Every
// accepted level is run through an exact integer model of the compressor
// curve, and each gain that leaves the core is compared in order against it.
// ============================================================================
module tb_soft_knee_gain_computer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import skgc_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RANDOM_PHASES   = 11;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_IDLE        = 16;
    localparam int MAX_PRINTED     = 40;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One outstanding gain, kept with the level that caused it.
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic signed [GAIN_W-1:0]  gain;
    } gain_expect_t;

    // Holds a copy of the registers, predicts the gain of each accepted level
    // and checks the gains in arrival order.
    class gain_checker;
        logic signed [THR_W-1:0] threshold;
        logic [KNEE_W-1:0]       knee;
        logic [RATIO_W-1:0]      ratio;
        gain_expect_t            pending_gain[$];
        int                      errors;
        int                      gains_checked;

        function new();
            threshold     = THRESHOLD_RST;
            knee          = KNEE_RST;
            ratio         = RATIO_RST;
            errors        = 0;
            gains_checked = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD: threshold = data[THR_W-1:0];
                REG_KNEE:      knee      = data[KNEE_W-1:0];
                REG_RATIO:     ratio     = data[RATIO_W-1:0];
                default:       ;
            endcase
        endfunction

        // Rounds num / den to nearest, ties away from zero.
        function longint unsigned round_div(input longint unsigned num,
                                            input longint unsigned den);
            return (num + den / 2) / den;
        endfunction

        // Exact gain curve: zero below the knee, quadratic inside it, linear
        // above it, with a hard knee when the width is zero.
        function logic signed [GAIN_W-1:0] compress_gain(
            input logic signed [LEVEL_W-1:0] level);
            longint          over;
            longint          knee_w;
            longint          two_over;
            longint unsigned r;
            longint unsigned slope;
            longint unsigned d;
            longint unsigned mag;
            over   = longint'(level) - longint'(threshold);
            knee_w = longint'(knee);
            // A ratio below one acts as one, which flattens the curve to zero.
            r      = (ratio < RATIO_ONE) ? longint'(RATIO_ONE) : longint'(ratio);
            slope  = r - longint'(RATIO_ONE);
            mag    = 0;
            if (knee_w > 0) begin
                two_over = 2 * over;
                if (two_over < -knee_w) begin
                    mag = 0;
                end
                else if (two_over <= knee_w) begin
                    d   = two_over + knee_w;
                    mag = round_div(slope * d * d, 8 * r * knee_w);
                end
                else begin
                    mag = round_div(slope * over, r);
                end
            end
            else if (over > 0) begin
                mag = round_div(slope * over, r);
            end
            if (mag > longint'(GAIN_MAG_MAX))
                mag = longint'(GAIN_MAG_MAX);
            return GAIN_W'(0 - mag);
        endfunction

        function void note_level(input logic signed [LEVEL_W-1:0] level);
            gain_expect_t item;
            item.level = level;
            item.gain  = compress_gain(level);
            pending_gain.push_back(item);
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTED)
                $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_gain(input logic signed [GAIN_W-1:0] got);
            gain_expect_t want;
            if (pending_gain.size() == 0) begin
                report($sformatf("gain %0d arrived with no level outstanding", got));
            end
            else begin
                want = pending_gain.pop_front();
                gains_checked++;
                if (got !== want.gain)
                    report($sformatf("level %0d (T=%0d W=%0d R=%0d): gain %0d, want %0d",
                                     want.level, threshold, knee, ratio, got, want.gain));
            end
        endtask
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    bit          source_gaps;
    bit          sink_stalls;
    int          cycle_count   = 0;
    int          levels_sent   = 0;
    int          settings_used = 1;
    gain_checker sb;

    skgc_level_if level_ch();
    skgc_gain_if  gain_ch();
    skgc_cfg_if   cfg_ch();

    soft_knee_gain_computer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .level (level_ch),
        .gain  (gain_ch),
        .cfg   (cfg_ch)
    );

    // 4 ns clock.
    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d gains still outstanding.",
                     cycle_count, sb.pending_gain.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Handshakes are judged at the falling edge, where every signal is settled
    // for the rising edge that follows.
    task automatic send_level(input logic signed [LEVEL_W-1:0] level);
        int gap;
        gap = source_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            level_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        level_ch.valid    <= 1'b1;
        level_ch.level_db <= level;
        do @(negedge clk); while (!level_ch.ready);
        @(posedge clk);
        sb.note_level(level);
        levels_sent++;
    endtask

    // Sink side: stalls a random number of cycles before each item.
    task automatic receive_gains();
        int                       stall;
        logic signed [GAIN_W-1:0] got;
        forever begin
            stall = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                gain_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            gain_ch.ready <= 1'b1;
            do @(negedge clk); while (!gain_ch.valid);
            got = gain_ch.gain_db;
            @(posedge clk);
            sb.check_gain(got);
        end
    endtask

    // Holds the source off until every outstanding gain has come back.
    task automatic wait_for_gains();
        level_ch.valid <= 1'b0;
        while (sb.pending_gain.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Writes all three registers plus a junk write to the unused index.
    task automatic configure(input logic [CFG_DATA_W-1:0] thr_word,
                             input logic [CFG_DATA_W-1:0] knee_word,
                             input logic [CFG_DATA_W-1:0] ratio_word);
        write_reg(REG_THRESHOLD, thr_word);
        write_reg(REG_KNEE, knee_word);
        write_reg(REG_RATIO, ratio_word);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Random register setting; the first two phases take the ends of the random ranges.
    task automatic random_configure(input int phase);
        logic [CFG_DATA_W-1:0] thr_word;
        logic [CFG_DATA_W-1:0] knee_word;
        logic [CFG_DATA_W-1:0] ratio_word;
        thr_word   = CFG_DATA_W'($urandom);
        knee_word  = CFG_DATA_W'($urandom);
        ratio_word = CFG_DATA_W'($urandom);
        case (phase)
            0: begin
                thr_word[THR_W-1:0]     = THR_W'(-15360);
                knee_word[KNEE_W-1:0]   = '0;
                ratio_word[RATIO_W-1:0] = RATIO_ONE;
            end
            1: begin
                thr_word[THR_W-1:0]     = '0;
                knee_word[KNEE_W-1:0]   = KNEE_W'(6144);
                ratio_word[RATIO_W-1:0] = RATIO_W'(512);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: thr_word[THR_W-1:0] = THR_W'(-15360);
                    1: thr_word[THR_W-1:0] = '0;
                    2: thr_word[THR_W-1:0] = THR_W'(-int'($urandom_range(0, 15360)));
                    3: ;
                    default: thr_word[THR_W-1:0] = THRESHOLD_RST;
                endcase
                case ($urandom_range(0, 4))
                    0: knee_word[KNEE_W-1:0] = '0;
                    1: knee_word[KNEE_W-1:0] = KNEE_W'(6144);
                    2: knee_word[KNEE_W-1:0] = KNEE_W'($urandom_range(0, 6144));
                    3: ;
                    default: knee_word[KNEE_W-1:0] = KNEE_W'($urandom_range(1, 16));
                endcase
                case ($urandom_range(0, 4))
                    0: ratio_word[RATIO_W-1:0] = RATIO_ONE;
                    1: ratio_word[RATIO_W-1:0] = RATIO_W'(512);
                    2: ratio_word[RATIO_W-1:0] = RATIO_W'($urandom_range(0, 15));
                    3: ratio_word[RATIO_W-1:0] = RATIO_W'($urandom_range(16, 512));
                    default: ;
                endcase
            end
        endcase
        configure(thr_word, knee_word, ratio_word);
    endtask

    // Levels mostly around the knee, some anywhere, some right on its edges.
    function automatic logic signed [LEVEL_W-1:0] pick_level();
        int span;
        int lv;
        span = int'(sb.knee) + 64;
        case ($urandom_range(0, 9))
            0, 1, 2: lv = int'($signed(LEVEL_W'($urandom)));
            9: lv = int'(sb.threshold)
                    + ($urandom_range(0, 1) ? 1 : -1) * (int'(sb.knee) / 2)
                    + int'($urandom_range(0, 2)) - 1;
            default: lv = int'(sb.threshold) + int'($urandom_range(0, 2 * span)) - span;
        endcase
        if (lv > 32767)
            lv = 32767;
        if (lv < -32768)
            lv = -32768;
        return LEVEL_W'(lv);
    endfunction

    initial
    begin
        int phase;
        int n;
        sb                = new();
        level_ch.valid    = 1'b0;
        level_ch.level_db = '0;
        gain_ch.ready     = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_THRESHOLD;
        cfg_ch.data       = '0;
        source_gaps       = 1'b1;
        sink_stalls       = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        fork
            receive_gains();
        join_none

        // Reset setting: field extremes and both edges of the 6 dB knee.
        send_level(16'sh8000);
        send_level(16'sh7FFF);
        send_level(16'sd0);
        send_level(-16'sd5889);
        send_level(-16'sd5888);
        send_level(-16'sd5120);
        send_level(-16'sd4352);
        send_level(-16'sd4351);
        wait_for_gains();

        // Hard knee at 0 dB, 2:1, where odd overshoots land on rounding ties.
        configure(16'h0000, 16'h0000, 16'd32);
        send_level(-16'sd1);
        send_level(16'sd0);
        send_level(16'sd1);
        send_level(16'sd3);
        send_level(16'sh7FFF);
        wait_for_gains();

        // Lowest threshold, widest knee and steepest ratio: output saturates.
        configure(16'h4000, 16'h1FFF, 16'h03FF);
        send_level(16'sh7FFF);
        send_level(16'sh8000);
        send_level(-16'sd16384);
        send_level(16'sd0);
        wait_for_gains();

        // Ratio of zero and just below one: no gain change anywhere.
        configure(16'hEC00, 16'd1536, 16'd0);
        send_level(16'sh7FFF);
        send_level(16'sd0);
        wait_for_gains();
        configure(16'h6C00, 16'd1536, 16'd15);
        send_level(16'sh7FFF);
        wait_for_gains();

        // Threshold above 0 dB with the widest knee that the random phases use.
        configure(16'h3FFF, 16'd6144, 16'd512);
        send_level(16'sh7FFF);
        send_level(16'sd16383);
        send_level(16'sd13311);
        send_level(16'sh8000);

        // Random phases, each with its own setting and idle pattern.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_gains();
            random_configure(phase);
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 2) == 0)
                    wait_for_gains();
                send_level(pick_level());
            end
        end

        wait_for_gains();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d levels under %0d register settings; %0d gains compared.",
                 levels_sent, settings_used, sb.gains_checked);
        $display("Mismatches seen: %0d.", sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
